// ----- src/tlb_page_table_translator_defines.svh -----
// Assertion macros for the checker file of the translator.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLBPT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tlbpt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TLBPT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tlbpt assertion failed");

`endif

// ----- src/tlbpt_pkg.sv -----
`default_nettype none

package tlbpt_pkg;

    localparam int VA_W          = 22;
    localparam int PA_W          = 16;
    localparam int STATUS_W      = 2;
    localparam int CNT_W         = 32;
    localparam int TABLE_ENTRIES = 1024;
    localparam int VPN_W         = $clog2(TABLE_ENTRIES);

    localparam int TLB_ENTRIES_DEF = 8;
    localparam int FRAME_COUNT_DEF = 16;
    localparam int OFFSET_BITS_DEF = 12;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 144;
    localparam int M_TUSER_W = 3;

    localparam int HIT_LSB    = PA_W;
    localparam int MISS_LSB   = HIT_LSB + CNT_W;
    localparam int FAULT_LSB  = MISS_LSB + CNT_W;
    localparam int ACCESS_LSB = FAULT_LSB + CNT_W;

    localparam logic [STATUS_W-1:0] STAT_HIT         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS        = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FAULT_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FAULT_NONE  = 2'd3;

endpackage

`default_nettype wire

// ----- src/tlb_page_table_translator.sv -----
// Translates one virtual address request at a time through an eight-way (TLB_ENTRIES) fully
// associative TLB backed by a 1024-entry page table with a bump frame allocator. After reset
// the block clears every page table entry and holds s_tready low meanwhile. A single
// page comparator then steps through the TLB slots, one slot per cycle: a hit ends the search
// at its slot and goes straight to the output state, and a miss, found after the last slot,
// first updates the page table and the TLB in the miss state before its result shows. The
// block takes its next request in the cycle after the result leaves on the master side.
`default_nettype none

module tlb_page_table_translator
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int FRAME_COUNT = FRAME_COUNT_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [21:0] virtual_address, [23:22] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] is_write
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [15:0] physical_address, [47:16] hit_count, [79:48] miss_count,
    // [111:80] fault_count, [143:112] access_count
    output logic [M_TDATA_W-1:0]      m_tdata,
    // [1:0] access_status, [2] page_dirty
    output logic [M_TUSER_W-1:0]      m_tuser
);

    localparam int IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int FREE_W  = $clog2(FRAME_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TLB_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_MISS,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               dirty;
        logic               accessed;
        logic               present;
        logic [FRAME_W-1:0] frame;
    } tbl_entry_t;

    state_t                 state_reg, state_next;
    logic [VPN_W-1:0]       clr_idx_reg, clr_idx_next;
    logic [VPN_W-1:0]       page_reg, page_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic                   wr_reg, wr_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [FREE_W-1:0]      free_reg, free_next;
    logic [TLB_ENTRIES-1:0] tlb_valid_reg, tlb_valid_next;
    logic [CNT_W-1:0]       hits_reg, hits_next;
    logic [CNT_W-1:0]       misses_reg, misses_next;
    logic [CNT_W-1:0]       faults_reg, faults_next;
    logic [CNT_W-1:0]       accesses_reg, accesses_next;
    logic [PA_W-1:0]        pa_reg, pa_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   dirty_reg, dirty_next;

    logic [VPN_W-1:0]     tlb_page_mem [TLB_ENTRIES];
    logic [FRAME_W-1:0]   tlb_frame_mem [TLB_ENTRIES];
    logic [VPN_W-1:0]     tlb_rd_page_reg;
    logic [FRAME_W-1:0]   tlb_rd_frame_reg;
    tbl_entry_t           table_mem [TABLE_ENTRIES];
    tbl_entry_t           tbl_rd_reg;

    logic                 tlb_re, tlb_we;
    logic [IDX_W-1:0]     tlb_ra;
    logic                 tbl_re, tbl_we;
    logic [VPN_W-1:0]     tbl_ra, tbl_wa;
    tbl_entry_t           tbl_wd;
    tbl_entry_t           new_ent;
    logic                 accept, match;
    logic [FRAME_W-1:0]   frame_sel;
    logic [31:0]          va_ext, pa_wide;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {accesses_reg, faults_reg, misses_reg, hits_reg, pa_reg};
    assign m_tuser  = {dirty_reg, status_reg};

    assign va_ext = 32'(s_tdata[VA_W-1:0]) >> OFFSET_BITS;
    assign match  = tlb_valid_reg[idx_reg] && (tlb_rd_page_reg == page_reg);

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        page_next      = page_reg;
        offset_next    = offset_reg;
        wr_next        = wr_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        free_next      = free_reg;
        tlb_valid_next = tlb_valid_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        faults_next    = faults_reg;
        accesses_next  = accesses_reg;
        pa_next        = pa_reg;
        status_next    = status_reg;
        dirty_next     = dirty_reg;
        tlb_re         = 1'b0;
        tlb_we         = 1'b0;
        tlb_ra         = '0;
        tbl_re         = 1'b0;
        tbl_we         = 1'b0;
        tbl_ra         = va_ext[VPN_W-1:0];
        tbl_wa         = page_reg;
        tbl_wd         = '0;
        new_ent        = tbl_rd_reg;
        frame_sel      = tlb_rd_frame_reg;
        case (state_reg)
            ST_CLEAR: begin
                tbl_we = 1'b1;
                tbl_wa = clr_idx_reg;
                if (clr_idx_reg == {VPN_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    page_next   = va_ext[VPN_W-1:0];
                    offset_next = s_tdata[OFFSET_BITS-1:0];
                    wr_next     = s_tuser[0];
                    idx_next    = '0;
                    tlb_re      = 1'b1;
                    tbl_re      = 1'b1;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (match) begin
                    status_next   = STAT_HIT;
                    dirty_next    = tbl_rd_reg.dirty;
                    hits_next     = hits_reg + 1'b1;
                    accesses_next = accesses_reg + 1'b1;
                    state_next    = ST_OUT;
                end else if (idx_reg == LAST_SLOT) begin
                    state_next = ST_MISS;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    tlb_re   = 1'b1;
                    tlb_ra   = idx_reg + 1'b1;
                end
            end
            ST_MISS: begin
                status_next   = STAT_MISS;
                misses_next   = misses_reg + 1'b1;
                accesses_next = accesses_reg + 1'b1;
                if (!tbl_rd_reg.present) begin
                    faults_next = faults_reg + 1'b1;
                    if (free_reg < FREE_W'(FRAME_COUNT)) begin
                        new_ent.frame   = free_reg[FRAME_W-1:0];
                        new_ent.present = 1'b1;
                        new_ent.dirty   = 1'b0;
                        free_next       = free_reg + 1'b1;
                        status_next     = STAT_FAULT_ALLOC;
                    end else begin
                        status_next = STAT_FAULT_NONE;
                    end
                end
                new_ent.accessed = 1'b1;
                if (wr_reg) begin
                    new_ent.dirty = 1'b1;
                end
                frame_sel = new_ent.frame;
                tbl_we    = 1'b1;
                tbl_wd    = new_ent;
                tlb_we    = 1'b1;
                tlb_valid_next[slot_reg] = 1'b1;
                slot_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                dirty_next = new_ent.dirty;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        pa_wide = (32'(frame_sel) << OFFSET_BITS) | 32'(offset_reg);
        if (state_reg == ST_SEARCH || state_reg == ST_MISS) begin
            pa_next = pa_wide[PA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            idx_reg       <= '0;
            slot_reg      <= '0;
            free_reg      <= '0;
            tlb_valid_reg <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            faults_reg    <= '0;
            accesses_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            idx_reg       <= idx_next;
            slot_reg      <= slot_next;
            free_reg      <= free_next;
            tlb_valid_reg <= tlb_valid_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            faults_reg    <= faults_next;
            accesses_reg  <= accesses_next;
        end
        page_reg   <= page_next;
        offset_reg <= offset_next;
        wr_reg     <= wr_next;
        pa_reg     <= pa_next;
        status_reg <= status_next;
        dirty_reg  <= dirty_next;
    end

    always_ff @(posedge aclk) begin
        if (tlb_we) begin
            tlb_page_mem[slot_reg]  <= page_reg;
            tlb_frame_mem[slot_reg] <= new_ent.frame;
        end
        if (tlb_re) begin
            tlb_rd_page_reg  <= tlb_page_mem[tlb_ra];
            tlb_rd_frame_reg <= tlb_frame_mem[tlb_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            table_mem[tbl_wa] <= tbl_wd;
        end
        if (tbl_re) begin
            tbl_rd_reg <= table_mem[tbl_ra];
        end
    end

endmodule

`default_nettype wire

// ----- src/tlbpt_checker.sv -----
`default_nettype none
`include "tlb_page_table_translator_defines.svh"

module tlbpt_checker
    import tlbpt_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    // Every access is counted either as a hit or as a miss.
    `TLBPT_ASSERT_IMP(a_count_sum, aclk, aresetn, m_tvalid, m_tdata[ACCESS_LSB +: CNT_W] == m_tdata[HIT_LSB +: CNT_W] + m_tdata[MISS_LSB +: CNT_W])

    // A new request is never taken while a result is pending.
    `TLBPT_ASSERT_IMP(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !m_tvalid)

    // In the cycle after a request is accepted, no result is shown yet and no new request is taken.
    `TLBPT_ASSERT_NXT(a_no_early_result, aclk, aresetn, s_tvalid && s_tready, !m_tvalid && !s_tready)

    // A stalled result holds.
    `TLBPT_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import tlbpt_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int HOT_PAGES      = 12;

    typedef struct packed {
        logic [PA_W-1:0]     phys_addr;
        logic [STATUS_W-1:0] status;
        logic                dirty;
        logic [CNT_W-1:0]    hits;
        logic [CNT_W-1:0]    misses;
        logic [CNT_W-1:0]    faults;
        logic [CNT_W-1:0]    accesses;
    } translation_t;

    class translation_scoreboard;
        bit [VPN_W-1:0]     slot_page [TLB_ENTRIES_DEF];
        bit [3:0]           slot_frame[TLB_ENTRIES_DEF];
        bit                 slot_valid[TLB_ENTRIES_DEF];
        int                 next_slot;
        bit [3:0]           pte_frame   [TABLE_ENTRIES];
        bit                 pte_present [TABLE_ENTRIES];
        bit                 pte_accessed[TABLE_ENTRIES];
        bit                 pte_dirty   [TABLE_ENTRIES];
        bit [4:0]           alloc_frame_ptr;
        bit [CNT_W-1:0]     hits, misses, faults, accesses;
        translation_t       pending_translations[$];
        int                 error_count;

        function new();
            next_slot   = 0;
            error_count = 0;
        endfunction

        function int pending();
            return pending_translations.size();
        endfunction

        function void note_request(logic [VA_W-1:0] va, logic is_write);
            logic [VPN_W-1:0]           page;
            logic [OFFSET_BITS_DEF-1:0] offset;
            logic [3:0]                 frame;
            logic [STATUS_W-1:0]        status;
            bit                         found;
            translation_t               exp;
            page   = va[OFFSET_BITS_DEF +: VPN_W];
            offset = va[OFFSET_BITS_DEF-1:0];
            frame  = '0;
            found  = 0;
            accesses++;
            for (int i = 0; i < TLB_ENTRIES_DEF; i++) begin
                if (!found && slot_valid[i] && slot_page[i] == page) begin
                    frame = slot_frame[i];
                    found = 1;
                end
            end
            if (found) begin
                hits++;
                status = STAT_HIT;
            end else begin
                misses++;
                status = STAT_MISS;
                if (!pte_present[page]) begin
                    faults++;
                    if (alloc_frame_ptr < FRAME_COUNT_DEF) begin
                        pte_frame[page]    = alloc_frame_ptr[3:0];
                        alloc_frame_ptr++;
                        pte_present[page]  = 1;
                        pte_accessed[page] = 0;
                        pte_dirty[page]    = 0;
                        status = STAT_FAULT_ALLOC;
                    end else begin
                        status = STAT_FAULT_NONE;
                    end
                end
                pte_accessed[page] = 1;
                if (is_write) begin
                    pte_dirty[page] = 1;
                end
                frame = pte_frame[page];
                slot_page[next_slot]  = page;
                slot_frame[next_slot] = frame;
                slot_valid[next_slot] = 1;
                next_slot = (next_slot == TLB_ENTRIES_DEF - 1) ? 0 : next_slot + 1;
            end
            exp.phys_addr = PA_W'({frame, offset});
            exp.status    = status;
            exp.dirty     = pte_dirty[page];
            exp.hits      = hits;
            exp.misses    = misses;
            exp.faults    = faults;
            exp.accesses  = accesses;
            pending_translations.push_back(exp);
        endfunction

        function void compare_field(string name, logic [CNT_W-1:0] exp_val,
                                    logic [CNT_W-1:0] act_val);
            if (exp_val !== act_val) begin
                error_count++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $realtime, name, exp_val, act_val);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
            translation_t exp;
            if (pending_translations.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h",
                         $realtime, data, user);
                return;
            end
            exp = pending_translations.pop_front();
            compare_field("physical_address", exp.phys_addr, data[PA_W-1:0]);
            compare_field("access_status", exp.status, user[STATUS_W-1:0]);
            compare_field("page_dirty", exp.dirty, user[STATUS_W]);
            compare_field("hit_count", exp.hits, data[HIT_LSB +: CNT_W]);
            compare_field("miss_count", exp.misses, data[MISS_LSB +: CNT_W]);
            compare_field("fault_count", exp.faults, data[FAULT_LSB +: CNT_W]);
            compare_field("access_count", exp.accesses, data[ACCESS_LSB +: CNT_W]);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    translation_scoreboard sb;
    logic [VPN_W-1:0]      hot_pages[HOT_PAGES];
    bit                    no_idle;
    int                    mode_cycles;
    int                    stall_left;
    int                    quiet_cycles;

    tlb_page_table_translator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Requests and results are recorded from the values seen just before each edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_request(s_tdata[VA_W-1:0], s_tuser[0]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL tlb_page_table_translator");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Alternates between stretches with random idling and stretches without any.
    always @(posedge aclk) begin
        if (mode_cycles == 0) begin
            no_idle     <= ($urandom_range(0, 3) == 0);
            mode_cycles <= $urandom_range(100, 400);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 99) < 20) begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_access(logic [VPN_W-1:0] page, logic [OFFSET_BITS_DEF-1:0] offset,
                               logic is_write);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({page, offset});
        s_tuser  <= is_write;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Drops the request line and waits, between edges, until every result is back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    initial begin
        logic [VPN_W-1:0]           page;
        logic [OFFSET_BITS_DEF-1:0] offset;
        int                         r;
        sb           = new();
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        m_tready     <= 1'b0;
        no_idle      <= 1'b0;
        mode_cycles  <= 0;
        stall_left   <= 0;
        quiet_cycles <= 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // First touch faults, then a write that hits leaves the dirty mark alone.
        send_access(10'd0, 12'h000, 1'b0);
        send_access(10'd0, 12'h123, 1'b1);
        send_access(10'h3FF, 12'hFFF, 1'b1);
        // Enough new pages to wrap the replacement pointer and evict the first two.
        for (int p = 1; p <= 8; p++) begin
            send_access(p[VPN_W-1:0], 12'hA5A, 1'b0);
        end
        send_access(10'd0, 12'h5A5, 1'b1);
        send_access(10'h3FF, 12'h001, 1'b0);
        // Use up the remaining frames, then fault with none left.
        for (int p = 9; p <= 14; p++) begin
            send_access(p[VPN_W-1:0], 12'hFFF, p[0]);
        end
        send_access(10'd500, 12'h800, 1'b1);
        send_access(10'd500, 12'h7FF, 1'b0);
        send_access(10'd501, 12'h000, 1'b0);

        for (int i = 0; i < HOT_PAGES; i++) begin
            hot_pages[i] = (i < 10) ? i[VPN_W-1:0] : (i == 10 ? 10'h3FF : 10'd500);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400 || n == 900) begin
                wait_drained();
            end
            if ($urandom_range(0, 99) < 5) begin
                hot_pages[$urandom_range(0, HOT_PAGES - 1)] =
                    VPN_W'($urandom_range(0, TABLE_ENTRIES - 1));
            end
            r = $urandom_range(0, 99);
            page = (r < 80) ? hot_pages[$urandom_range(0, HOT_PAGES - 1)]
                            : VPN_W'($urandom_range(0, TABLE_ENTRIES - 1));
            r = $urandom_range(0, 9);
            offset = (r == 0) ? '0 : (r == 1) ? '1
                                              : OFFSET_BITS_DEF'($urandom_range(0, 4095));
            send_access(page, offset, 1'($urandom_range(0, 1)));
        end

        wait_drained();
        repeat (4 * TLB_ENTRIES_DEF) @(posedge aclk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("PASS tlb_page_table_translator");
        end else begin
            $display("FAIL tlb_page_table_translator");
        end
        $finish;
    end

endmodule
